// File: hdl/evhp_pkg.sv
// Shared types and constants of the Ethernet 802.1Q header parser.
// No dependencies; imported by every module of the block.
package evhp_pkg;

  localparam int unsigned FifoDepth = 4;

  localparam int unsigned PosWidth = 5;

  // Header byte positions, counted from the first destination MAC byte
  localparam logic [PosWidth-1:0] PosSrcStart = 5'd6;
  localparam logic [PosWidth-1:0] PosType0    = 5'd12;
  localparam logic [PosWidth-1:0] PosType1    = 5'd13;
  localparam logic [PosWidth-1:0] PosTag0     = 5'd14;
  localparam logic [PosWidth-1:0] PosTag1     = 5'd15;
  localparam logic [PosWidth-1:0] PosInner0   = 5'd16;

  localparam logic [15:0] TpidReset = 16'h8100;

  typedef enum logic [1:0] {
    KindHeader  = 2'd0,
    KindPayload = 2'd1,
    KindTrunc   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    kind_e        kind;
    logic [47:0]  dest_mac;
    logic [47:0]  src_mac;
    logic [15:0]  ether_type;
    logic         has_vlan;
    logic [2:0]   vlan_pcp;
    logic         vlan_dei;
    logic [11:0]  vlan_id;
    logic [7:0]   payload_byte;
    logic         is_last;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// File: hdl/evhp_front.sv
// Front end of the parser: takes frame bytes, collects the header and
// classifies the bytes into header, payload and truncation requests. Depends on evhp_pkg.
module evhp_front
  import evhp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  in_item_t    in_data_i,
  input  logic [15:0] tpid_i,
  output logic        push_o,
  output out_item_t   res_o
);

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [47:0]         dest_q, dest_d;
  logic [47:0]         src_q, src_d;
  logic [15:0]         type_q, type_d;
  logic [15:0]         tag_q, tag_d;
  logic                tag_seen_q, tag_seen_d;
  logic                in_payload_q, in_payload_d;

  logic [15:0] type_next;
  logic        done;
  logic        last;
  logic [7:0]  b;

  assign b         = in_data_i.data_byte;
  assign last      = in_data_i.frame_last;
  assign type_next = {type_q[7:0], b};

  always_comb begin
    pos_d        = pos_q;
    dest_d       = dest_q;
    src_d        = src_q;
    type_d       = type_q;
    tag_d        = tag_q;
    tag_seen_d   = tag_seen_q;
    in_payload_d = in_payload_q;
    done         = 1'b0;
    push_o       = 1'b0;
    res_o        = '0;

    if (take_i) begin
      if (in_payload_q) begin
        res_o.kind         = KindPayload;
        res_o.payload_byte = b;
        res_o.is_last      = last;
        push_o             = 1'b1;
      end else begin
        if (pos_q < PosSrcStart) begin
          dest_d = {dest_q[39:0], b};
        end else if (pos_q < PosType0) begin
          src_d = {src_q[39:0], b};
        end else if (pos_q == PosType0 || pos_q == PosInner0) begin
          type_d = type_next;
        end else if (pos_q == PosType1) begin
          type_d = type_next;
          if (type_next == tpid_i) begin
            tag_seen_d = 1'b1;
          end else begin
            done = 1'b1;
          end
        end else if (pos_q == PosTag0 || pos_q == PosTag1) begin
          tag_d = {tag_q[7:0], b};
        end else begin
          type_d = type_next;
          done   = 1'b1;
        end
        pos_d = pos_q + 1'b1;

        if (done) begin
          res_o.kind       = KindHeader;
          res_o.dest_mac   = dest_q;
          res_o.src_mac    = src_q;
          res_o.ether_type = type_next;
          if (tag_seen_q) begin
            res_o.has_vlan = 1'b1;
            res_o.vlan_pcp = tag_q[15:13];
            res_o.vlan_dei = tag_q[12];
            res_o.vlan_id  = tag_q[11:0];
          end
          res_o.is_last = last;
          push_o        = 1'b1;
          in_payload_d  = ~last;
        end else if (last) begin
          res_o.kind    = KindTrunc;
          res_o.is_last = 1'b1;
          push_o        = 1'b1;
        end
      end

      // End of frame: start the next one from scratch
      if (last) begin
        pos_d        = '0;
        dest_d       = '0;
        src_d        = '0;
        type_d       = '0;
        tag_d        = '0;
        tag_seen_d   = 1'b0;
        in_payload_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      dest_q       <= '0;
      src_q        <= '0;
      type_q       <= '0;
      tag_q        <= '0;
      tag_seen_q   <= 1'b0;
      in_payload_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      dest_q       <= dest_d;
      src_q        <= src_d;
      type_q       <= type_d;
      tag_q        <= tag_d;
      tag_seen_q   <= tag_seen_d;
      in_payload_q <= in_payload_d;
    end
  end

  a_header_not_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && res_o.kind == KindHeader |-> !in_payload_q)
    else $error("header request while passing payload");

endmodule

// File: hdl/evhp_fifo.sv
// Short request queue between the parser front end and the output stage.
// Depends on evhp_pkg.
module evhp_fifo
  import evhp_pkg::*;
#(
  parameter int unsigned Depth = FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  out_item_t  push_data_i,
  input  logic       pop_i,
  output out_item_t  pop_data_o,
  output fifo_stat_t stat_o
);

  localparam int unsigned IdxWidth = $clog2(Depth);
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

  out_item_t mem_q [Depth];
  logic [IdxWidth-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full))
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && stat_o.empty))
    else $error("request popped from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

// File: hdl/evhp_back.sv
// Output stage: moves queued result requests into the output register.
// Depends on evhp_pkg.
module evhp_back
  import evhp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  out_item_t  head_i,
  input  fifo_stat_t stat_i,
  output logic       pop_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_item_t  out_data_o
);

  logic      valid_q, valid_d;
  out_item_t data_q;

  // Load when the register is free or is being taken this cycle
  assign pop_o       = !stat_i.empty && (!valid_q || !out_stall_i);
  assign valid_d     = pop_o || (valid_q && out_stall_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

endmodule

// File: hdl/ethernet_vlan_header_parser.sv
// Top level of the Ethernet 802.1Q header parser: TPID register and the
// front end, request queue and output stage. Depends on evhp_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one frame
//   byte per request plus a flag on the last byte of the frame. Output
//   channel (out_valid_o / out_stall_i / out_data_o) carries results: one
//   header result when the header completes (with any 802.1Q tag split into
//   PCP, DEI and VLAN ID), then one result per payload byte, or a single
//   truncation result when a frame ends inside its header.
//   Configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes
//   the TPID that marks a tag; always ready. Write it only while idle.
//   Throughput: one byte per cycle while the queue is not full. Result path:
//   an accepted request is written into the queue, then moved into the
//   output register once it reaches the queue head and that register is free.
//   Reset: the TPID returns to 0x8100, the queue empties and parsing
//   restarts at the first byte of a frame.
//   Receiver stall: the output register holds its result; the queue absorbs
//   up to Depth requests before in_stall_o rises.
module ethernet_vlan_header_parser
  import evhp_pkg::*;
#(
  parameter int unsigned Depth = FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] tpid_q, tpid_d;
  fifo_stat_t  stat;
  logic        take;
  logic        push;
  logic        pop;
  out_item_t   res;
  out_item_t   head;

  // Hold new bytes off only while the queue is full
  assign in_stall_o  = stat.full;
  assign take        = in_valid_i && !stat.full;
  assign cfg_ready_o = 1'b1;
  assign tpid_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : tpid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpid_q <= TpidReset;
    end else begin
      tpid_q <= tpid_d;
    end
  end

  evhp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_data_i (in_data_i),
    .tpid_i    (tpid_q),
    .push_o    (push),
    .res_o     (res)
  );

  evhp_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .pop_i       (pop),
    .pop_data_o  (head),
    .stat_o      (stat)
  );

  evhp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (stat),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
